// ----- rtl/cmr_pkg.sv -----
// ----------------------------------------------------------------------------
// cmr_pkg: shared types and constants for the complex magnitude block
// Widths of the datapath and one step of the digit-by-digit square root.
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAG_BITS        = 16;
  localparam int SUM_W           = 2 * SAMPLE_BITS;
  localparam int ROOT_W          = SAMPLE_BITS;
  localparam int REM_W           = ROOT_W + 2;
  localparam int STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES     = (ROOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  // abs, square and sum stages, then the root stages, then the rounding register
  localparam int LATENCY         = 3 + SQRT_STAGES + 1;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [ROOT_W-1:0]      root_t;
  typedef logic [REM_W-1:0]       rem_t;
  typedef logic [MAG_BITS-1:0]    mag_t;

  typedef struct packed {
    rem_t  rem;
    root_t root;
    sum_t  rad;
  } sqrt_state_t;

  // one result bit: bring down two radicand bits, try (root << 2) | 1
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t st);
    rem_t        rem_sh;
    rem_t        trial;
    sqrt_state_t nx;
    rem_sh = {st.rem[REM_W-3:0], st.rad[SUM_W-1 -: 2]};
    trial  = {st.root, 2'b01};
    nx.rad = {st.rad[SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      nx.rem  = rem_sh - trial;
      nx.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      nx.rem  = rem_sh;
      nx.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return nx;
  endfunction

endpackage

// ----- rtl/cmr_square_sum.sv -----
// ----------------------------------------------------------------------------
// cmr_square_sum: sum of squares front end
// Three stages: absolute values, the two squares, their sum.
// ----------------------------------------------------------------------------
module cmr_square_sum (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [cmr_pkg::SAMPLE_BITS-1:0] real_part_i,
  input  logic signed [cmr_pkg::SAMPLE_BITS-1:0] imag_part_i,
  output logic                    valid_o,
  output cmr_pkg::sum_t           sum_o
);

  cmr_pkg::sample_t re_u, im_u;
  cmr_pkg::sample_t abs_re_d, abs_im_d, abs_re_q, abs_im_q;
  cmr_pkg::sum_t    sq_re_d, sq_im_d, sq_re_q, sq_im_q;
  cmr_pkg::sum_t    sum_d, sum_q;
  logic [2:0]       vld_q;

  assign re_u = cmr_pkg::sample_t'(real_part_i);
  assign im_u = cmr_pkg::sample_t'(imag_part_i);

  // the most negative code negates to itself, which is the right unsigned value
  assign abs_re_d = re_u[cmr_pkg::SAMPLE_BITS-1] ? (~re_u + 1'b1) : re_u;
  assign abs_im_d = im_u[cmr_pkg::SAMPLE_BITS-1] ? (~im_u + 1'b1) : im_u;

  assign sq_re_d = cmr_pkg::sum_t'(abs_re_q) * cmr_pkg::sum_t'(abs_re_q);
  assign sq_im_d = cmr_pkg::sum_t'(abs_im_q) * cmr_pkg::sum_t'(abs_im_q);

  // at most 2^(SUM_W-1), so no carry out
  assign sum_d = sq_re_q + sq_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    abs_re_q <= abs_re_d;
    abs_im_q <= abs_im_d;
    sq_re_q  <= sq_re_d;
    sq_im_q  <= sq_im_d;
    sum_q    <= sum_d;
  end

  assign valid_o = vld_q[2];
  assign sum_o   = sum_q;

`ifndef SYNTH
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!sum_o[cmr_pkg::SUM_W-1] || (sum_o[cmr_pkg::SUM_W-2:0] == '0)))
    else $error("sum of squares above 2^(SUM_W-1)");
`endif

endmodule

// ----- rtl/cmr_sqrt.sv -----
// ----------------------------------------------------------------------------
// cmr_sqrt: pipelined integer square root
// Restoring digit-by-digit root, two result bits per register stage; gives
// floor(sqrt(s)) and the remainder s - root^2.
// ----------------------------------------------------------------------------
module cmr_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  cmr_pkg::sum_t  sum_i,
  output logic           valid_o,
  output cmr_pkg::root_t root_o,
  output cmr_pkg::rem_t  rem_o
);

  cmr_pkg::sqrt_state_t           st_q  [cmr_pkg::SQRT_STAGES];
  cmr_pkg::sqrt_state_t           st_in [cmr_pkg::SQRT_STAGES];
  logic [cmr_pkg::SQRT_STAGES-1:0] vld_q;

  for (genvar g = 0; g < cmr_pkg::SQRT_STAGES; g++) begin : g_stage
    cmr_pkg::sqrt_state_t step_d;

    if (g == 0) begin : g_first
      assign st_in[g] = '{rem: '0, root: '0, rad: sum_i};
    end else begin : g_next
      assign st_in[g] = st_q[g-1];
    end

    always_comb begin
      step_d = st_in[g];
      for (int j = 0; j < cmr_pkg::STEPS_PER_STAGE; j++) begin
        if (g * cmr_pkg::STEPS_PER_STAGE + j < cmr_pkg::ROOT_W) begin
          step_d = cmr_pkg::sqrt_step(step_d);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[g] <= step_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[cmr_pkg::SQRT_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[cmr_pkg::SQRT_STAGES-1];
  assign root_o  = st_q[cmr_pkg::SQRT_STAGES-1].root;
  assign rem_o   = st_q[cmr_pkg::SQRT_STAGES-1].rem;

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rem_o <= {root_o, 1'b0}))
    else $error("square root remainder exceeds twice the root");
`endif

endmodule

// ----- rtl/complex_magnitude_rounded.sv -----
// ----------------------------------------------------------------------------
// complex_magnitude_rounded: rounded magnitude of a complex bin
// sqrt(re^2 + im^2) rounded to the nearest integer, fully pipelined.
// ----------------------------------------------------------------------------
// A new bin is taken on every clock where start_i is high; busy_o is always
// low, so words may stream in back to back with no gaps. Each result appears
// on magnitude_o with done_o high for one cycle, once its start_i has passed
// through the absolute value, squaring and summing registers, the square
// root stages (two root bits per stage over 16 bits) and the round-to-nearest
// register. Results come out in input order; the block holds no state
// between bins.
module complex_magnitude_rounded (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [cmr_pkg::SAMPLE_BITS-1:0] real_part_i,
  input  logic signed [cmr_pkg::SAMPLE_BITS-1:0] imag_part_i,
  output logic                                   done_o,
  output logic        [cmr_pkg::MAG_BITS-1:0]    magnitude_o
);

  logic                     accept;
  logic                     sum_vld;
  cmr_pkg::sum_t            sum;
  logic                     root_vld;
  cmr_pkg::root_t           root;
  cmr_pkg::rem_t            rem;
  logic [cmr_pkg::ROOT_W:0] rnd;
  cmr_pkg::mag_t            mag_d, mag_q;
  logic                     done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  cmr_square_sum u_square_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .valid_o     (sum_vld),
    .sum_o       (sum)
  );

  cmr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_vld),
    .sum_i   (sum),
    .valid_o (root_vld),
    .root_o  (root),
    .rem_o   (rem)
  );

  // round up when s - r^2 > r, i.e. sqrt(s) >= r + 0.5
  assign rnd   = {1'b0, root} + {{cmr_pkg::ROOT_W{1'b0}}, (rem > cmr_pkg::rem_t'(root))};
  assign mag_d = cmr_pkg::mag_t'(rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= root_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  assign done_o      = done_q;
  assign magnitude_o = mag_q;

`ifndef SYNTH
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, cmr_pkg::LATENCY))
    else $error("result word without a matching start");

  a_zero_in_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(accept && (real_part_i == '0) && (imag_part_i == '0),
                     cmr_pkg::LATENCY)) |-> (magnitude_o == '0))
    else $error("zero bin gave a nonzero magnitude");
`endif

endmodule

// ----- test/complex_magnitude_rounded_tb.sv -----
// ----------------------------------------------------------------------------
// complex_magnitude_rounded_tb: self-checking bench for the magnitude block
// Streams complex bins into the block and checks every rounded magnitude
// against a bit-accurate integer square root, in order, with or without random gaps.
// ----------------------------------------------------------------------------
module complex_magnitude_rounded_tb;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic                     done_o;
  logic [cmr_pkg::SAMPLE_BITS-1:0] real_part_i;
  logic [cmr_pkg::SAMPLE_BITS-1:0] imag_part_i;
  logic [cmr_pkg::MAG_BITS-1:0]    magnitude_o;

  cmr_pkg::mag_t expected_mags[$];
  int unsigned   mismatch_count;
  bit            gaps_on;

  complex_magnitude_rounded dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .real_part_i (real_part_i),
    .imag_part_i (imag_part_i),
    .done_o      (done_o),
    .magnitude_o (magnitude_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // exact rounded sqrt(re^2 + im^2), built up one root bit at a time
  function automatic cmr_pkg::mag_t rounded_magnitude(cmr_pkg::sample_t re,
                                                      cmr_pkg::sample_t im);
    longint          abs_re;
    longint          abs_im;
    longint unsigned sum_sq;
    longint unsigned root;
    longint unsigned cand;
    abs_re = $signed(re);
    abs_im = $signed(im);
    if (abs_re < 0) abs_re = -abs_re;
    if (abs_im < 0) abs_im = -abs_im;
    sum_sq = abs_re * abs_re + abs_im * abs_im;
    root = 0;
    for (int k = 16; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      if (cand * cand <= sum_sq) root = cand;
    end
    if (sum_sq > root * root + root) root = root + 1;
    return cmr_pkg::mag_t'(root);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // accepted words queue their expectation; results are checked in order
  always @(posedge clk_i) begin
    cmr_pkg::mag_t want;
    if (rst_ni) begin
      if (start_i && !busy_o)
        expected_mags.push_back(rounded_magnitude(real_part_i, imag_part_i));
      if (done_o) begin
        if (expected_mags.size() == 0) begin
          report_mismatch($sformatf("unexpected result magnitude=%0d", magnitude_o));
        end else begin
          want = expected_mags.pop_front();
          if (magnitude_o !== want)
            report_mismatch($sformatf("magnitude got %0d want %0d", magnitude_o, want));
        end
      end
    end
  end

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i     <= 1'b0;
      real_part_i <= cmr_pkg::sample_t'($urandom);
      imag_part_i <= cmr_pkg::sample_t'($urandom);
    end
  endtask

  task automatic send_word(cmr_pkg::sample_t re, cmr_pkg::sample_t im);
    @(negedge clk_i);
    start_i     <= 1'b1;
    real_part_i <= re;
    imag_part_i <= im;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    if (gaps_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 9));
  endtask

  task automatic wait_all_results();
    while (expected_mags.size() != 0) @(posedge clk_i);
    repeat (cmr_pkg::LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic cmr_pkg::sample_t rand_small(int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return cmr_pkg::sample_t'(v);
  endfunction

  task automatic test_extremes();
    gaps_on = 1'b1;
    send_word(16'sd0, 16'sd0);
    send_word(-16'sd32768, -16'sd32768);
    send_word(16'sd32767, 16'sd32767);
    send_word(-16'sd32768, 16'sd32767);
    send_word(16'sd32767, -16'sd32768);
    send_word(-16'sd32768, 16'sd0);
    send_word(16'sd0, -16'sd32768);
    send_word(16'sd32767, 16'sd0);
    send_word(16'sd0, 16'sd32767);
    send_word(16'sd1, 16'sd0);
    send_word(16'sd0, -16'sd1);
    send_word(-16'sd1, -16'sd1);
    send_word(16'sd1, 16'sd1);
    // sums sitting right on and just past the rounding threshold, and an exact square
    send_word(16'sd4, 16'sd2);
    send_word(16'sd3, -16'sd2);
    send_word(-16'sd4, 16'sd3);
    send_word(16'h5555, 16'hAAAA);
    send_word(16'hAAAA, 16'h5555);
    send_word(16'hFFFF, 16'h8001);
    send_word(16'h7FFF, 16'h8001);
  endtask

  task automatic test_random_full_range(int unsigned n);
    gaps_on = 1'b1;
    repeat (n) send_word(cmr_pkg::sample_t'($urandom), cmr_pkg::sample_t'($urandom));
  endtask

  task automatic test_small_values(int unsigned n);
    gaps_on = 1'b1;
    repeat (n) send_word(rand_small(64), rand_small(64));
  endtask

  task automatic test_pause_for_drain(int unsigned n);
    gaps_on = 1'b1;
    repeat (n) send_word(cmr_pkg::sample_t'($urandom), rand_small(300));
    idle_cycles(1);
    wait_all_results();
    repeat (n) send_word(rand_small(300), cmr_pkg::sample_t'($urandom));
  endtask

  task automatic test_back_to_back(int unsigned n);
    gaps_on = 1'b0;
    repeat (n) send_word(cmr_pkg::sample_t'($urandom), cmr_pkg::sample_t'($urandom));
    idle_cycles(1);
  endtask

  initial begin
    mismatch_count = 0;
    gaps_on        = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    real_part_i    = '0;
    imag_part_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_random_full_range(700);
    test_small_values(300);
    test_pause_for_drain(50);
    test_back_to_back(250);

    wait_all_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- complex_magnitude_rounded.f -----
rtl/cmr_pkg.sv
rtl/cmr_square_sum.sv
rtl/cmr_sqrt.sv
rtl/complex_magnitude_rounded.sv
test/complex_magnitude_rounded_tb.sv
